/* rtl/day_number_to_calendar_date_macros.svh */
// Assertion macros shared by the calendar date converter
`ifndef DAY_NUMBER_TO_CALENDAR_DATE_MACROS_SVH
`define DAY_NUMBER_TO_CALENDAR_DATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed cycle delay, checked outside reset.
`define DNC_ASSERT_DLY(lbl, ck, rs, ante, n, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

/* rtl/dnc_pkg.sv */
// Types, constants and tables for the day count to calendar date converter
`timescale 1ns / 1ps
package dnc_pkg;

  typedef logic signed [22:0] count_t;
  typedef logic signed [14:0] year_t;
  typedef logic [3:0]         month_t;
  typedef logic [4:0]         mday_t;
  typedef logic [2:0]         wday_t;

  localparam int unsigned LATENCY = 11;

  localparam logic signed [23:0] JD_OFFSET     = 24'sd2444239;
  localparam logic signed [23:0] GREG_START_JD = 24'sd2299161;
  // count + WEEK_BIAS is never negative and equals count + 1 modulo 7
  localparam logic [23:0]        WEEK_BIAS     = 24'd4194310;

  localparam logic [24:0] ALPHA_NUM_OFS = 25'd7468865;
  localparam logic [23:0] B_OFS         = 24'd1524;
  localparam logic [29:0] C_NUM_OFS     = 30'd12210;
  localparam logic [29:0] C_NUM_SCALE   = 30'd100;
  localparam logic [25:0] D_SCALE       = 26'd1461;
  localparam logic [22:0] E_NUM_SCALE   = 23'd10000;
  localparam logic [3:0]  E_WRAP        = 4'd13;
  localparam logic [3:0]  E_EARLY_OFS   = 4'd1;
  localparam logic [3:0]  MONTH_FEB     = 4'd2;
  localparam logic signed [15:0] YEAR_OFS_LATE  = 16'sd4716;
  localparam logic signed [15:0] YEAR_OFS_EARLY = 16'sd4715;

  // Reciprocals: floor(n/D) == (n*M) >> S for every n below 2^(S - bits(D))
  localparam int unsigned WEEK_SHIFT  = 27;
  localparam logic [24:0] WEEK_RECIP  =
    25'(((64'd1 << WEEK_SHIFT) + 64'd6) / 64'd7);
  localparam int unsigned ALPHA_SHIFT = 43;
  localparam logic [25:0] ALPHA_RECIP =
    26'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);
  localparam int unsigned C_SHIFT     = 46;
  localparam logic [30:0] C_RECIP     =
    31'(((64'd1 << C_SHIFT) + 64'd36524) / 64'd36525);
  localparam int unsigned E_SHIFT     = 42;
  localparam logic [23:0] E_RECIP     =
    24'(((64'd1 << E_SHIFT) + 64'd306000) / 64'd306001);

  // floor(30.6001 * e)
  function automatic logic [8:0] month_days_before(input logic [3:0] e);
    logic [8:0] f;
    case (e)
      4'd0:    f = 9'd0;
      4'd1:    f = 9'd30;
      4'd2:    f = 9'd61;
      4'd3:    f = 9'd91;
      4'd4:    f = 9'd122;
      4'd5:    f = 9'd153;
      4'd6:    f = 9'd183;
      4'd7:    f = 9'd214;
      4'd8:    f = 9'd244;
      4'd9:    f = 9'd275;
      4'd10:   f = 9'd306;
      4'd11:   f = 9'd336;
      4'd12:   f = 9'd367;
      4'd13:   f = 9'd397;
      4'd14:   f = 9'd428;
      default: f = 9'd459;
    endcase
    return f;
  endfunction

endpackage

/* rtl/day_number_to_calendar_date.sv */
// Day count to calendar date converter, pipelined
`timescale 1ns / 1ps
`include "day_number_to_calendar_date_macros.svh"

// Converts a signed day count (1 = 1980-01-01) to year, month, day of month and
// weekday (1 = Sunday). Dates before 1582-10-15 come out in the Julian calendar,
// later ones in the Gregorian; there is no year zero. Counts below Julian day 0
// set out_of_range and zero year, month and day, with the weekday still valid.
// A transaction is taken on every cycle with start high: busy is always low.
// Each result is registered through the pipeline and appears on done, in order,
// for one cycle. The pipeline depth comes from the chain of three reciprocal multiplies
// (century term, year, month), each with a register on either side.
module day_number_to_calendar_date (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dnc_pkg::count_t day_count,
  output logic            done,
  output dnc_pkg::year_t  year_out,
  output dnc_pkg::month_t month_out,
  output dnc_pkg::mday_t  day_of_month,
  output dnc_pkg::wday_t  weekday_out,
  output logic            out_of_range
);
  import dnc_pkg::*;

  // valid bits, one per stage
  logic [10:1] vld;

  // stage 1
  logic signed [23:0] s1_z;
  logic [23:0]        s1_v;
  logic               s1_greg;
  // stage 2
  logic [50:0]        s2_prod_alpha;
  logic [48:0]        s2_prod_week;
  logic [2:0]         s2_v_lo;
  logic [22:0]        s2_z;
  logic               s2_greg;
  logic               s2_neg;
  // stages 3..10
  logic [22:0]        s3_b, s4_b, s5_b, s6_b;
  logic [29:0]        s4_n2;
  logic [60:0]        s5_prod_c;
  logic [14:0]        s6_c, s7_c, s8_c, s9_c, s10_c;
  logic [8:0]         s7_bd, s8_bd, s9_bd;
  logic [22:0]        s8_n3;
  logic [46:0]        s9_prod_e;
  logic [3:0]         s10_e;
  logic [4:0]         s10_mday;
  logic [2:0]         s3_wk, s4_wk, s5_wk, s6_wk, s7_wk, s8_wk, s9_wk, s10_wk;
  logic               s3_neg, s4_neg, s5_neg, s6_neg, s7_neg, s8_neg, s9_neg, s10_neg;

  // combinational terms
  logic signed [23:0] z_calc;
  logic [24:0]        n_alpha;
  logic [7:0]         alpha;
  logic [7:0]         alpha_adj;
  logic [23:0]        b_sum;
  logic [21:0]        week_q;
  logic [2:0]         week_rem;
  logic [25:0]        d_prod;
  logic [23:0]        bd_full;
  logic [3:0]         e_calc;
  logic [8:0]         mday_full;
  logic [3:0]         month_calc;
  logic signed [15:0] year_raw;
  logic signed [15:0] year_calc;

  assign busy = 1'b0;

  assign z_calc    = {day_count[22], day_count} + JD_OFFSET;
  assign n_alpha   = s1_greg ? ({s1_z[22:0], 2'b00} - ALPHA_NUM_OFS) : '0;
  assign alpha     = s2_prod_alpha[ALPHA_SHIFT +: 8];
  assign alpha_adj = alpha - {2'b00, alpha[7:2]};
  assign b_sum     = {1'b0, s2_z} + (s2_greg ? (24'(alpha_adj) + 24'd1) : 24'd0) + B_OFS;
  assign week_q    = s2_prod_week[WEEK_SHIFT +: 22];
  assign week_rem  = s2_v_lo - 3'(week_q[2:0] * 3'd7);
  assign d_prod    = 26'(s6_c) * D_SCALE;
  assign bd_full   = {1'b0, s6_b} - d_prod[25:2];
  assign e_calc    = s9_prod_e[E_SHIFT +: 4];
  assign mday_full = s9_bd - month_days_before(e_calc);

  always_comb begin
    month_calc = (s10_e > E_WRAP) ? (s10_e - E_WRAP) : (s10_e - E_EARLY_OFS);
    year_raw   = $signed({1'b0, s10_c}) -
                 ((month_calc > MONTH_FEB) ? YEAR_OFS_LATE : YEAR_OFS_EARLY);
    year_calc  = (year_raw < 16'sd1) ? (year_raw - 16'sd1) : year_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[9:1], start & ~busy};
      done <= vld[10];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: Julian day number, Gregorian select, weekday operand
    s1_z    <= z_calc;
    s1_v    <= 24'({day_count[22], day_count}) + WEEK_BIAS;
    s1_greg <= (z_calc >= GREG_START_JD);
    // stage 2: century term and weekday quotient
    s2_prod_alpha <= 51'(n_alpha) * 51'(ALPHA_RECIP);
    s2_prod_week  <= 49'(s1_v) * 49'(WEEK_RECIP);
    s2_v_lo       <= s1_v[2:0];
    s2_z          <= s1_z[22:0];
    s2_greg       <= s1_greg;
    s2_neg        <= s1_z[23];
    // stage 3: b
    s3_b   <= b_sum[22:0];
    s3_wk  <= week_rem + 3'd1;
    s3_neg <= s2_neg;
    // stage 4: year numerator
    s4_n2  <= 30'(s3_b) * C_NUM_SCALE - C_NUM_OFS;
    s4_b   <= s3_b;
    s4_wk  <= s3_wk;
    s4_neg <= s3_neg;
    // stage 5
    s5_prod_c <= 61'(s4_n2) * 61'(C_RECIP);
    s5_b      <= s4_b;
    s5_wk     <= s4_wk;
    s5_neg    <= s4_neg;
    // stage 6: c
    s6_c   <= s5_prod_c[C_SHIFT +: 15];
    s6_b   <= s5_b;
    s6_wk  <= s5_wk;
    s6_neg <= s5_neg;
    // stage 7: days into the year, b - d
    s7_bd  <= bd_full[8:0];
    s7_c   <= s6_c;
    s7_wk  <= s6_wk;
    s7_neg <= s6_neg;
    // stage 8: month numerator
    s8_n3  <= 23'(s7_bd) * E_NUM_SCALE;
    s8_bd  <= s7_bd;
    s8_c   <= s7_c;
    s8_wk  <= s7_wk;
    s8_neg <= s7_neg;
    // stage 9
    s9_prod_e <= 47'(s8_n3) * 47'(E_RECIP);
    s9_bd     <= s8_bd;
    s9_c      <= s8_c;
    s9_wk     <= s8_wk;
    s9_neg    <= s8_neg;
    // stage 10: e and day of month
    s10_e    <= e_calc;
    s10_mday <= mday_full[4:0];
    s10_c    <= s9_c;
    s10_wk   <= s9_wk;
    s10_neg  <= s9_neg;
    // output register
    weekday_out  <= s10_wk;
    out_of_range <= s10_neg;
    if (s10_neg) begin
      year_out     <= '0;
      month_out    <= '0;
      day_of_month <= '0;
    end else begin
      year_out     <= year_calc[14:0];
      month_out    <= month_calc;
      day_of_month <= s10_mday;
    end
  end

  `DNC_ASSERT_DLY(a_latency, clk, rst, start && !busy, LATENCY, done, "result strobe missing after fixed latency")
  `DNC_ASSERT_IMP(a_oor_zero, clk, rst, done && out_of_range, year_out == '0 && month_out == '0 && day_of_month == '0, "out of range result has nonzero date")
  `DNC_ASSERT_IMP(a_date_legal, clk, rst, done && !out_of_range, month_out != 4'd0 && month_out <= 4'd12 && day_of_month != 5'd0 && year_out != '0, "illegal calendar date")
  `DNC_ASSERT_IMP(a_wday_legal, clk, rst, done, weekday_out != 3'd0, "weekday out of range")

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the day count to calendar date converter
`timescale 1ns / 1ps

module testbench;
  import dnc_pkg::*;

  typedef struct packed {
    year_t  year;
    month_t month;
    mday_t  mday;
    wday_t  wday;
    logic   oor;
  } cal_date_t;

  typedef struct {
    count_t    cnt;
    bit        typed;
    cal_date_t date;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 185;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      start     = 1'b0;
  count_t    day_count = '0;
  logic      busy;
  logic      done;
  year_t     year_out;
  month_t    month_out;
  mday_t     day_of_month;
  wday_t     weekday_out;
  logic      out_of_range;

  int unsigned error_count = 0;
  cal_date_t   pending_dates[$];
  // expectation for the transaction currently on the inputs
  cal_date_t   drive_date = '0;

  // Dates typed in where they follow directly; '0 rows go through the predictor.
  stim_row_t directed_rows [20] = '{
    '{23'sd1,         1'b1, '{15'sd1980, 4'd1, 5'd1, 3'd3, 1'b0}},   // epoch, a Tuesday
    '{23'sd0,         1'b1, '{15'sd1979, 4'd12, 5'd31, 3'd2, 1'b0}},
    '{-23'sd1,        1'b0, '0},
    '{23'sd60,        1'b0, '0},                                     // 1980-02-29
    '{23'sd7365,      1'b0, '0},                                     // 2000-02-29
    '{-23'sd29160,    1'b0, '0},                                     // 1900-02-28
    '{-23'sd29159,    1'b0, '0},                                     // 1900-03-01
    '{-23'sd145078,   1'b1, '{15'sd1582, 4'd10, 5'd15, 3'd6, 1'b0}}, // first Gregorian day
    '{-23'sd145079,   1'b1, '{15'sd1582, 4'd10, 5'd4, 3'd5, 1'b0}},  // last Julian day
    '{-23'sd200000,   1'b0, '0},
    '{-23'sd722815,   1'b1, '{15'sd1, 4'd1, 5'd1, 3'd7, 1'b0}},      // 1 AD
    '{-23'sd722816,   1'b1, '{-15'sd1, 4'd12, 5'd31, 3'd6, 1'b0}},   // 1 BC, no year zero
    '{-23'sd2444239,  1'b1, '{-15'sd4713, 4'd1, 5'd1, 3'd2, 1'b0}},  // Julian day zero
    '{-23'sd2444240,  1'b1, '{15'sd0, 4'd0, 5'd0, 3'd1, 1'b1}},      // just below range
    '{23'h400000,     1'b1, '{15'sd0, 4'd0, 5'd0, 3'd7, 1'b1}},      // most negative count
    '{23'h3FFFFF,     1'b0, '0},                                     // most positive count
    '{23'sd2973000,   1'b0, '0},
    '{23'h2AAAAA,     1'b0, '0},
    '{23'h555555,     1'b0, '0},
    '{-23'sd2444238,  1'b0, '0}
  };

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  day_number_to_calendar_date u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .day_count    (day_count),
    .done         (done),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_of_month (day_of_month),
    .weekday_out  (weekday_out),
    .out_of_range (out_of_range)
  );

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  // Julian day inversion, all fractional constants scaled to integers
  function automatic cal_date_t date_of_count(input count_t cnt);
    longint    n, z, a, b, c, d, e, alpha, mo, yr, wk;
    cal_date_t r;
    n  = longint'(cnt);
    r  = '0;
    wk = (n + 1) % 7;
    if (wk < 0) wk = wk + 7;
    r.wday = wday_t'(wk + 1);
    z = n + 2444239;
    if (z < 0) begin
      r.oor = 1'b1;
      return r;
    end
    if (z < 2299161) begin
      a = z;
    end else begin
      alpha = floor_quot(4 * z - 7468865, 146097);
      a = z + 1 + alpha - floor_quot(alpha, 4);
    end
    b  = a + 1524;
    c  = floor_quot(100 * b - 12210, 36525);
    d  = floor_quot(1461 * c, 4);
    e  = floor_quot(10000 * (b - d), 306001);
    mo = (e > 13) ? e - 13 : e - 1;
    yr = (mo > 2) ? c - 4716 : c - 4715;
    if (yr < 1) yr = yr - 1;
    r.year  = year_t'(yr);
    r.month = month_t'(mo);
    r.mday  = mday_t'(b - d - floor_quot(306001 * e, 10000));
    return r;
  endfunction

  // Mostly valid dates, weighted toward calendar switch, year zero and range edges
  function automatic count_t pick_count();
    int unsigned sel;
    int          v;
    sel = $urandom_range(99, 0);
    if (sel < 55)      v = int'($urandom_range(5417239, 0)) - 2444239;
    else if (sel < 65) v = int'($urandom());
    else if (sel < 75) v = -145078 + int'($urandom_range(800, 0)) - 400;
    else if (sel < 83) v = -722815 + int'($urandom_range(1600, 0)) - 800;
    else if (sel < 90) v = -2444239 + int'($urandom_range(100, 0)) - 50;
    else if (sel < 95) v = int'($urandom_range(4194303, 2973001));
    else               v = int'($urandom_range(8000, 0)) - 4000;
    return count_t'(v);
  endfunction

  task automatic send_count(input count_t cnt, input cal_date_t want, input int idle_pct);
    @(negedge clk);
    while (int'($urandom_range(99, 0)) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drive_date = want;
    day_count <= cnt;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  always @(posedge clk) begin
    cal_date_t got;
    cal_date_t want;
    if (!rst) begin
      if (start && busy === 1'b0) pending_dates.push_back(drive_date);
      if (done) begin
        got = '{year_out, month_out, day_of_month, weekday_out, out_of_range};
        if (pending_dates.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result y=%0d m=%0d d=%0d w=%0d oor=%0b", $realtime,
                   got.year, got.month, got.mday, got.wday, got.oor);
        end else begin
          want = pending_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.mday !== want.mday ||
              got.wday !== want.wday || got.oor !== want.oor) begin
            error_count++;
            $display("%0t: expected y=%0d m=%0d d=%0d w=%0d oor=%0b, actual y=%0d m=%0d d=%0d w=%0d oor=%0b",
                     $realtime, want.year, want.month, want.mday, want.wday, want.oor,
                     got.year, got.month, got.mday, got.wday, got.oor);
          end
        end
      end
    end
  end

  initial begin
    cal_date_t want;
    count_t    cnt;
    int        idle_pct [3];
    idle_pct = '{31, 48, 0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      want = directed_rows[i].typed ? directed_rows[i].date : date_of_count(directed_rows[i].cnt);
      send_count(directed_rows[i].cnt, want, idle_pct[0]);
    end
    for (int p = 0; p < 3; p++) begin
      repeat (RANDOM_PER_PHASE) begin
        cnt = pick_count();
        send_count(cnt, date_of_count(cnt), idle_pct[p]);
      end
    end
    @(negedge clk);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dnc_pkg.sv
rtl/day_number_to_calendar_date.sv
tb/testbench.sv
